// ----- rtl/u8d_pkg.sv -----
// ============================================================================
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Holds the decoder state and result structs and the byte class constants.
// ============================================================================
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEFT_W  = 2;

    // Byte class masks and patterns.
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_PAT  = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;

    // Continuation slot counts opened by each lead byte class.
    localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'd65533;

    typedef struct packed {
        logic [CP_W-1:0]   partial_glyph;
        logic [LEFT_W-1:0] bytes_left;
        logic              seq_valid;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            ready_res;
    } dec_result_t;

endpackage

`default_nettype wire

// ----- rtl/u8d_if.sv -----
// ============================================================================
// u8d_if: request channels of the UTF-8 stream decoder
// A byte channel into the decoder and a code point channel out of it.
// ============================================================================
`default_nettype none

interface u8d_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::BYTE_W-1:0]   byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_cp_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::CP_W-1:0]   code_point;
    logic                       ready_res;

    modport source (output valid, output code_point, output ready_res, input ready);
    modport sink   (input valid, input code_point, input ready_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8d_step.sv -----
// ============================================================================
// u8d_step: one decoding step
// Computes the next decoder state and the result for one incoming byte.
// ============================================================================
`default_nettype none

module u8d_step (
    input  wire u8d_pkg::dec_state_t        state_cur,
    input  wire logic [u8d_pkg::BYTE_W-1:0] byte_in,
    output u8d_pkg::dec_state_t             state_nxt,
    output u8d_pkg::dec_result_t            result
);

    logic is_cont;

    assign is_cont = (byte_in & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_PAT;

    // Continuation slot handling or lead byte classification.
    always_comb
    begin
        state_nxt = state_cur;
        if (state_cur.bytes_left != u8d_pkg::LEFT_NONE)
        begin
            if (state_cur.seq_valid)
            begin
                if (is_cont)
                begin
                    state_nxt.partial_glyph = {state_cur.partial_glyph[u8d_pkg::CP_W-7:0],
                                               byte_in[5:0]};
                end
                else
                begin
                    state_nxt.seq_valid = 1'b0;
                end
            end
            state_nxt.bytes_left = state_cur.bytes_left - u8d_pkg::LEFT_ONE;
        end
        else if ((byte_in & u8d_pkg::ASCII_MASK) == u8d_pkg::ASCII_PAT)
        begin
            state_nxt.seq_valid     = 1'b1;
            state_nxt.partial_glyph = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, byte_in};
        end
        else if ((byte_in & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT)
        begin
            state_nxt.seq_valid     = 1'b1;
            state_nxt.bytes_left    = u8d_pkg::LEFT_ONE;
            state_nxt.partial_glyph = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}},
                                       byte_in & u8d_pkg::LEAD2_DATA};
        end
        else if ((byte_in & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT)
        begin
            state_nxt.seq_valid     = 1'b1;
            state_nxt.bytes_left    = u8d_pkg::LEFT_TWO;
            state_nxt.partial_glyph = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}},
                                       byte_in & u8d_pkg::LEAD3_DATA};
        end
        else if ((byte_in & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT)
        begin
            state_nxt.seq_valid     = 1'b1;
            state_nxt.bytes_left    = u8d_pkg::LEFT_THREE;
            state_nxt.partial_glyph = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}},
                                       byte_in & u8d_pkg::LEAD4_DATA};
        end
        else
        begin
            // Stray continuation byte or an invalid lead byte.
            state_nxt.seq_valid = 1'b0;
        end
    end

    // Result: zero while a sequence stays open, else the glyph or the replacement.
    always_comb
    begin
        if (state_nxt.bytes_left != u8d_pkg::LEFT_NONE)
        begin
            result.code_point = '0;
            result.ready_res  = 1'b0;
        end
        else
        begin
            result.code_point = state_nxt.seq_valid ? state_nxt.partial_glyph
                                                    : u8d_pkg::REPLACEMENT_CP;
            result.ready_res  = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder_top.sv -----
// ============================================================================
// utf8_stream_decoder_top: byte-serial UTF-8 to code point decoder
// Input byte register, one decoding step, and a result register.
// ============================================================================
// Usage:
//   byte_ch carries one raw UTF-8 byte per request; cp_ch returns exactly one
//   result request per byte, in order. While a multi-byte sequence is still
//   open the result is code_point 0 with ready_res 0; the byte that closes a
//   sequence returns the decoded code point with ready_res 1, or 65533 when
//   the sequence was malformed.
//   A byte accepted on byte_ch is held in the byte register, passes the
//   combinational decoding step, and is captured in the result register,
//   from which cp_ch shows it.
//   Throughput: one byte per cycle while cp_ch is not stalled; the decoding
//   step sits between the byte register and the result register.
//   Reset (rst_n low, asynchronous) empties both registers and clears the
//   decoder state: no sequence open, partial code point zero.
//   When the receiver stalls cp_ch, the result register holds its request
//   and one more byte waits in the byte register; byte_ch.ready then drops
//   until the result is taken.
// ============================================================================
`default_nettype none

module utf8_stream_decoder_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8d_byte_if.sink    byte_ch,
    u8d_cp_if.source    cp_ch
);

    logic                         in_valid_reg;
    logic [u8d_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                         out_valid_reg;
    u8d_pkg::dec_result_t         out_result_reg;
    u8d_pkg::dec_state_t          state_reg;
    u8d_pkg::dec_state_t          state_next;
    u8d_pkg::dec_result_t         result_next;
    logic                         step_fire;
    logic                         byte_take;

    // The byte register moves on when the result register is free or drains.
    assign step_fire     = in_valid_reg && (!out_valid_reg || cp_ch.ready);
    assign byte_ch.ready = !in_valid_reg || step_fire;
    assign byte_take     = byte_ch.valid && byte_ch.ready;

    u8d_step u_step (
        .state_cur (state_reg),
        .byte_in   (in_byte_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_byte_reg <= byte_ch.byte_in;
        end
    end

    // Decoder state advances with each decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || cp_ch.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_result_reg <= result_next;
        end
    end

    assign cp_ch.valid      = out_valid_reg;
    assign cp_ch.code_point = out_result_reg.code_point;
    assign cp_ch.ready_res  = out_result_reg.ready_res;

endmodule

`default_nettype wire

// ----- rtl/u8d_checker.sv -----
// ============================================================================
// u8d_checker: port-level checks of the UTF-8 stream decoder
// Watches the channel handshakes and result payloads over time.
// ============================================================================
`default_nettype none

module u8d_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [u8d_pkg::CP_W-1:0]     code_point,
    input wire logic                         ready_res
);

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(ready_res))
    else $error("u8d: stalled result changed");

    // An open sequence always reports a zero code point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ready_res |-> code_point == '0)
    else $error("u8d: open sequence with nonzero code point");

    // The byte channel only back-pressures behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("u8d: byte channel stalled without output stall");

    // A new result appears only after a byte request has passed through the byte register and the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("u8d: result without a byte request");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_ch.valid),
    .in_ready   (byte_ch.ready),
    .out_valid  (cp_ch.valid),
    .out_ready  (cp_ch.ready),
    .code_point (cp_ch.code_point),
    .ready_res  (cp_ch.ready_res)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the UTF-8 stream decoder
// Feeds raw bytes through the byte channel and predicts each result from a
// behavioral decoder kept in step with the block. Directed sequences cover
// the extremes, bad lead bytes and bad continuation bytes. A long random
// stream of mostly well-formed sequences follows, with noise mixed in.
// Both channels stall at random.
// ============================================================================

module testbench;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned STREAM_ITEMS = 1900;
    localparam int unsigned QUIET_ITEMS  = 300;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    u8d_byte_if byte_ch ();
    u8d_cp_if   cp_ch ();

    utf8_stream_decoder_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cp_ch   (cp_ch)
    );

    // Decoder state as the bench tracks it, and the code points still owed.
    u8d_pkg::dec_state_t   glyph_state;
    u8d_pkg::dec_result_t  pending_cps[$];
    int unsigned           fail_count;
    int unsigned           cycle_count;
    int unsigned           stream_sent;
    bit                    quiet;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Apply one byte to the tracked state and return the result it causes.
    function automatic u8d_pkg::dec_result_t decode_byte(
        input logic [u8d_pkg::BYTE_W-1:0] b);
        u8d_pkg::dec_result_t res;
        if (glyph_state.bytes_left != u8d_pkg::LEFT_NONE)
        begin
            if (glyph_state.seq_valid)
            begin
                if ((b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_PAT)
                    glyph_state.partial_glyph =
                        {glyph_state.partial_glyph[u8d_pkg::CP_W-7:0], b[5:0]};
                else
                    glyph_state.seq_valid = 1'b0;
            end
            glyph_state.bytes_left = glyph_state.bytes_left - u8d_pkg::LEFT_ONE;
        end
        else if ((b & u8d_pkg::ASCII_MASK) == u8d_pkg::ASCII_PAT)
        begin
            glyph_state.seq_valid     = 1'b1;
            glyph_state.partial_glyph = u8d_pkg::CP_W'(b);
        end
        else if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT)
        begin
            glyph_state.seq_valid     = 1'b1;
            glyph_state.bytes_left    = u8d_pkg::LEFT_ONE;
            glyph_state.partial_glyph = u8d_pkg::CP_W'(b & u8d_pkg::LEAD2_DATA);
        end
        else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT)
        begin
            glyph_state.seq_valid     = 1'b1;
            glyph_state.bytes_left    = u8d_pkg::LEFT_TWO;
            glyph_state.partial_glyph = u8d_pkg::CP_W'(b & u8d_pkg::LEAD3_DATA);
        end
        else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT)
        begin
            glyph_state.seq_valid     = 1'b1;
            glyph_state.bytes_left    = u8d_pkg::LEFT_THREE;
            glyph_state.partial_glyph = u8d_pkg::CP_W'(b & u8d_pkg::LEAD4_DATA);
        end
        else
        begin
            glyph_state.seq_valid = 1'b0;
        end

        if (glyph_state.bytes_left != u8d_pkg::LEFT_NONE)
        begin
            res.code_point = '0;
            res.ready_res  = 1'b0;
        end
        else
        begin
            res.code_point = glyph_state.seq_valid ? glyph_state.partial_glyph
                                                   : u8d_pkg::REPLACEMENT_CP;
            res.ready_res  = 1'b1;
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Hold the byte channel idle for a number of cycles.
    task automatic hold_sender(input int unsigned cycles);
        byte_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Send one byte request, with an occasional idle burst ahead of it.
    task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        if (!quiet && $urandom_range(0, 7) == 0)
            hold_sender($urandom_range(1, 6));
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        pending_cps.push_back(decode_byte(b));
    endtask

    // Send up to four bytes packed in a word, most significant byte first.
    task automatic send_seq(input logic [31:0] bytes, input int unsigned count);
        for (int i = int'(count) - 1; i >= 0; i--)
            send_byte(bytes[i*8 +: 8]);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (pending_cps.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each accepted request, then pick the next ready.
    int unsigned stall_left;

    always @(posedge clk)
    begin
        u8d_pkg::dec_result_t want;
        if (rst_n && cp_ch.valid && cp_ch.ready)
        begin
            if (pending_cps.size() == 0)
            begin
                note_failure($sformatf("unexpected result code_point=%0d ready_res=%0b",
                                       cp_ch.code_point, cp_ch.ready_res));
            end
            else
            begin
                want = pending_cps.pop_front();
                if (cp_ch.code_point !== want.code_point)
                    note_failure($sformatf("code_point expected %0d got %0d",
                                           want.code_point, cp_ch.code_point));
                if (cp_ch.ready_res !== want.ready_res)
                    note_failure($sformatf("ready_res expected %0b got %0b",
                                           want.ready_res, cp_ch.ready_res));
            end
        end

        if (!rst_n || quiet)
        begin
            cp_ch.ready <= rst_n;
            stall_left  = 0;
        end
        else if (stall_left > 0)
        begin
            cp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            cp_ch.ready <= 1'b0;
            stall_left  = $urandom_range(0, 5);
        end
        else
        begin
            cp_ch.ready <= 1'b1;
        end
    end

    // Lowest and highest values of one- and two-byte sequences, highest of three- and four-byte ones.
    task automatic test_extremes();
        send_seq(32'h00, 1);
        send_seq(32'h7F, 1);
        send_seq(32'hC280, 2);
        send_seq(32'hDFBF, 2);
        send_seq(32'hEFBFBF, 3);
        send_seq(32'hF7BFBFBF, 4);
    endtask

    // Stray continuation bytes and bytes that cannot start a sequence.
    task automatic test_bad_lead();
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hF8);
    endtask

    // A bad continuation still uses its slot; later bytes are not inspected.
    task automatic test_bad_continuation();
        send_seq(32'hC341, 2);
        send_seq(32'hE2FFFF, 3);
        send_seq(32'hF0C08041, 4);
    endtask

    // Let the block run empty in the middle of a stream.
    task automatic test_drain_pause();
        send_seq(32'hE282AC, 3);
        wait_drained();
        send_seq(32'hF09F9880, 4);
        send_seq(32'h41, 1);
    endtask

    task automatic send_random_sequence();
        int unsigned                 len;
        logic [u8d_pkg::BYTE_W-1:0]  r;
        r   = u8d_pkg::BYTE_W'($urandom);
        len = $urandom_range(1, 4);
        case (len)
            1: send_byte(r & ~u8d_pkg::ASCII_MASK);
            2: send_byte(u8d_pkg::LEAD2_PAT | (r & u8d_pkg::LEAD2_DATA));
            3: send_byte(u8d_pkg::LEAD3_PAT | (r & u8d_pkg::LEAD3_DATA));
            default: send_byte(u8d_pkg::LEAD4_PAT | (r & u8d_pkg::LEAD4_DATA));
        endcase
        stream_sent++;
        for (int unsigned i = 1; i < len; i++)
        begin
            send_byte(u8d_pkg::CONT_PAT |
                      (u8d_pkg::BYTE_W'($urandom) & u8d_pkg::CONT_DATA));
            stream_sent++;
        end
    endtask

    // Noise: a raw byte, a bad lead byte, or a sequence broken in one slot.
    task automatic send_noise();
        int unsigned                 len;
        int unsigned                 bad_slot;
        logic [u8d_pkg::BYTE_W-1:0]  r;
        r = u8d_pkg::BYTE_W'($urandom);
        case ($urandom_range(0, 2))
            0: send_byte(r);
            1: send_byte(r[0] ? (u8d_pkg::CONT_PAT | (r & u8d_pkg::CONT_DATA))
                              : (u8d_pkg::LEAD4_MASK | r));
            default:
            begin
                len      = $urandom_range(2, 4);
                bad_slot = $urandom_range(1, len - 1);
                case (len)
                    2: send_byte(u8d_pkg::LEAD2_PAT | (r & u8d_pkg::LEAD2_DATA));
                    3: send_byte(u8d_pkg::LEAD3_PAT | (r & u8d_pkg::LEAD3_DATA));
                    default: send_byte(u8d_pkg::LEAD4_PAT | (r & u8d_pkg::LEAD4_DATA));
                endcase
                stream_sent++;
                for (int unsigned i = 1; i < len; i++)
                begin
                    r = u8d_pkg::BYTE_W'($urandom);
                    if (i == bad_slot)
                        send_byte(r[7] ? (r | u8d_pkg::CONT_MASK) : r);
                    else if (i > bad_slot)
                        send_byte(r);
                    else
                        send_byte(u8d_pkg::CONT_PAT | (r & u8d_pkg::CONT_DATA));
                    stream_sent++;
                end
                return;
            end
        endcase
        stream_sent++;
    endtask

    task automatic test_random_stream();
        stream_sent = 0;
        while (stream_sent < STREAM_ITEMS)
        begin
            if (stream_sent >= STREAM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 80)
                send_random_sequence();
            else
                send_noise();
        end
    endtask

    initial
    begin
        fail_count      = 0;
        quiet           = 1'b0;
        glyph_state     = '0;
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_bad_lead();
        test_bad_continuation();
        test_drain_pause();
        test_random_stream();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_cps.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_cps.size()));

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder_top.sv
rtl/u8d_checker.sv
dv/testbench.sv
